// ===== rtl/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit-flip scanner package
// Shared constants and types for the memory bit-flip scanner.
// ----------------------------------------------------------------------------
package mbs_pkg;

   // Width of one buffer word and of one pattern register.
   localparam int WORD_BITS = 64;

   // Bits needed to name a bit inside one word.
   localparam int WORD_IDX_BITS = 6;

   // Number of pattern registers that hold one expected line.
   localparam int PATTERN_REGS = 8;

   // Bits needed to select a pattern register.
   localparam int PATTERN_SEL_BITS = 3;

   // Running word counter width.
   localparam int COUNTER_BITS = 26;

   // Width of the reported bit position.
   localparam int FLIP_POS_BITS = 32;

   // Configuration data and address widths (64-bit registers at 8-byte steps).
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_LINE_WORDS    = 8;
   localparam int DEFAULT_POSITION_BITS = 32;

   // One buffer word and the full bank of expected pattern words.
   typedef logic [WORD_BITS-1:0] word_type;
   typedef word_type pattern_bank_type [PATTERN_REGS];

endpackage

// ===== rtl/mbs_csr.sv =====
// ----------------------------------------------------------------------------
// Bit-flip scanner register file
// Holds the eight expected pattern words behind an APB-style port.
// ----------------------------------------------------------------------------
module mbs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mbs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mbs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mbs_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output mbs_pkg::pattern_bank_type          pattern
);
   import mbs_pkg::*;

   logic                        wr_en;
   logic [PATTERN_SEL_BITS-1:0] reg_sel;
   pattern_bank_type            pattern_ff;

   // Each register sits on an 8-byte boundary; the low address bits are ignored.
   assign reg_sel    = csr_paddr[CSR_ADDR_BITS-1:CSR_ADDR_BITS-PATTERN_SEL_BITS];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Pattern registers, all clear after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_REGS; k++) begin
            pattern_ff[k] <= '0;
         end
      end else if (wr_en) begin
         pattern_ff[reg_sel] <= csr_pwdata;
      end
   end

   // Read data is the addressed register.
   assign csr_prdata = pattern_ff[reg_sel];
   assign pattern    = pattern_ff;

endmodule

// ===== rtl/mbs_scan.sv =====
// ----------------------------------------------------------------------------
// Bit-flip scanner core
// Compares each word with its pattern word and walks the differing bits,
// lowest first, with one find-lowest-bit unit under a small sequencer.
// ----------------------------------------------------------------------------
module mbs_scan #(
   parameter int LINE_WORDS    = mbs_pkg::DEFAULT_LINE_WORDS,
   parameter int POSITION_BITS = mbs_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mbs_pkg::pattern_bank_type          pattern,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mbs_pkg::WORD_BITS-1:0]      req_data_word,
   input  logic                               req_buffer_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mbs_pkg::FLIP_POS_BITS-1:0]  rsp_flip_position,
   output logic                               rsp_run_last
);
   import mbs_pkg::*;

   // Phase counter runs over one line of words.
   localparam int PHASE_BITS = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
   localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(LINE_WORDS - 1);

   // Positions are kept to POSITION_BITS and then fit the output field.
   localparam int POS_KEEP = (POSITION_BITS < FLIP_POS_BITS) ? POSITION_BITS : FLIP_POS_BITS;
   localparam logic [FLIP_POS_BITS-1:0] POS_MASK =
      FLIP_POS_BITS'((65'd1 << POS_KEEP) - 65'd1);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                 state_ff, state_in;
   logic [WORD_BITS-1:0]      diff_ff, diff_in;
   logic [COUNTER_BITS-1:0]   count_ff, count_in;
   logic [COUNTER_BITS-1:0]   item_count_ff, item_count_in;
   logic [PHASE_BITS-1:0]     phase_ff, phase_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FLIP_POS_BITS-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [PATTERN_SEL_BITS-1:0] sel;
   logic [WORD_BITS-1:0]        diff_new;
   logic                        req_accept;
   logic                        out_free;
   logic [WORD_BITS-1:0]        lowest;
   logic [WORD_BITS-1:0]        rest;
   logic [WORD_IDX_BITS-1:0]    bit_idx;
   logic [FLIP_POS_BITS-1:0]    pos_full;

   // The pattern register is picked by the low three bits of the word's phase in the line.
   assign sel      = PATTERN_SEL_BITS'(phase_ff);
   assign diff_new = req_data_word ^ pattern[sel];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Find-lowest-bit unit: isolate the lowest set bit and clear it.
   assign lowest = diff_ff & (~diff_ff + WORD_BITS'(1));
   assign rest   = diff_ff & (diff_ff - WORD_BITS'(1));

   // Encode the isolated bit into its index.
   always_comb begin
      bit_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowest[i]) begin
            bit_idx = bit_idx | WORD_IDX_BITS'(i);
         end
      end
   end

   // Word number times 64 plus the bit index is a plain concatenation.
   assign pos_full = FLIP_POS_BITS'({item_count_ff, bit_idx});

   // Next-state logic for the sequencer, the counters and the output register.
   always_comb begin
      state_in      = state_ff;
      diff_in       = diff_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      item_count_in = item_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               diff_in       = diff_new;
               item_count_in = count_ff;
               // A matching word gives nothing and the next request may follow.
               if (diff_new != '0) begin
                  state_in = ST_SCAN;
               end
               // The counter clears after the buffer's last word and otherwise counts up, wrapping at its top.
               if (req_buffer_end) begin
                  count_in = '0;
                  phase_in = '0;
               end else begin
                  count_in = count_ff + COUNTER_BITS'(1);
                  if (count_ff == '1 || phase_ff == PHASE_LAST) begin
                     phase_in = '0;
                  end else begin
                     phase_in = phase_ff + PHASE_BITS'(1);
                  end
               end
            end
         end
         ST_SCAN: begin
            // Emit one differing bit whenever the output register can take it.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_full & POS_MASK;
               rsp_last_in  = (rest == '0);
               diff_in      = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control counters and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
      end
      diff_ff       <= diff_in;
      item_count_ff <= item_count_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flip_position = rsp_pos_ff;
   assign rsp_run_last      = rsp_last_ff;

endmodule

// ===== rtl/memory_bitflip_scanner.sv =====
// ----------------------------------------------------------------------------
// Memory bit-flip scanner
// Compares a stream of 64-bit buffer words with a 512-bit line pattern and
// reports the absolute position of every bit that differs.
// ----------------------------------------------------------------------------
// A word that matches its pattern word leaves the core idle, and the next
// request can be taken in the following cycle. A word with differing bits
// is walked by the shared find-lowest-bit unit, one bit per cycle while the
// result side does not stall, and the bits go to the output register lowest
// first; new requests stall until the last bit is out. Positions are the
// 26-bit word count times 64 plus the bit index, and the word count clears
// after a request marked as the buffer's end. The pattern registers sit at
// byte addresses 0, 8, ... 56 and all read as zero after reset.
module memory_bitflip_scanner #(
   parameter int LINE_WORDS    = mbs_pkg::DEFAULT_LINE_WORDS,
   parameter int POSITION_BITS = mbs_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mbs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mbs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mbs_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mbs_pkg::WORD_BITS-1:0]      req_data_word,
   input  logic                               req_buffer_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mbs_pkg::FLIP_POS_BITS-1:0]  rsp_flip_position,
   output logic                               rsp_run_last
);
   import mbs_pkg::*;

   pattern_bank_type pattern;

   // Pattern register file.
   mbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pattern     (pattern)
   );

   // Compare and bit-walk core.
   mbs_scan #(
      .LINE_WORDS    (LINE_WORDS),
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock             (clock),
      .reset             (reset),
      .pattern           (pattern),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_word     (req_data_word),
      .req_buffer_end    (req_buffer_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_flip_position (rsp_flip_position),
      .rsp_run_last      (rsp_run_last)
   );

endmodule
